// ===== hw/rtl/sms_pkg.sv =====
// Package for the scaled matrix product block.
// Holds sizes, codes, shared types and helper functions; no dependencies.
`default_nettype none
package sms_pkg;
	localparam int MAX_DIM    = 8;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_W   = 4;
	localparam int PROD_W  = 2 * DATA_WIDTH;
	localparam int ACC_W   = 64;
	localparam int HALF_W  = ACC_W / 2;
	localparam int SCALE_W = 32;
	localparam int SUM_W   = ACC_W + SCALE_W;
	localparam int SHIFT   = 2 * FRAC_BITS;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DIM_W-1:0] dim_t;
	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [SCALE_W-1:0] scale_t;

	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam acc_t  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [1:0] {
		FUNC_LOAD_A  = 2'd0,
		FUNC_LOAD_B  = 2'd1,
		FUNC_COMPUTE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		MODE_AB  = 2'd0,
		MODE_ATB = 2'd1,
		MODE_ABT = 2'd2,
		MODE_SYM = 2'd3
	} mode_t;

	localparam logic [2:0] REG_ROWS  = 3'd0;
	localparam logic [2:0] REG_INNER = 3'd1;
	localparam logic [2:0] REG_COLS  = 3'd2;
	localparam logic [2:0] REG_MODE  = 3'd3;
	localparam logic [2:0] REG_SCALE = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEED,
		ST_WAITROW,
		ST_RD,
		ST_LD,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic  vld;
		logic  first;
		logic  last;
		idx_t  k;
		data_t a;
	} feed_t;

	typedef struct packed {
		logic  we;
		idx_t  row;
		idx_t  col;
		data_t value;
	} bload_t;

	typedef struct packed {
		logic done;
		logic sat;
		acc_t acc;
	} cell_res_t;

	typedef struct packed {
		logic vld;
		logic sat;
		idx_t col;
		acc_t acc;
	} scale_in_t;

	typedef struct packed {
		logic  vld;
		logic  sat;
		idx_t  col;
		data_t value;
	} scale_out_t;

	function automatic addr_t mk_addr(idx_t r, idx_t c);
		return addr_t'(r) * addr_t'(MAX_DIM) + addr_t'(c);
	endfunction

	function automatic dim_t dim_clamp(dim_t r);
		if (r == '0) begin
			return dim_t'(1);
		end else if (r > dim_t'(MAX_DIM)) begin
			return dim_t'(MAX_DIM);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/sms_if.sv =====
// Valid/ready channel interfaces for the scaled matrix product block.
// Depends on sms_pkg for field widths.
`default_nettype none
interface sms_in_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      func;
	logic [sms_pkg::IDX_W-1:0]       row;
	logic [sms_pkg::IDX_W-1:0]       col;
	logic signed [31:0]              value;

	modport source(output valid, func, row, col, value, input ready);
	modport sink(input valid, func, row, col, value, output ready);
endinterface

interface sms_out_if;
	logic                            valid;
	logic                            ready;
	logic [sms_pkg::IDX_W-1:0]       out_row;
	logic [sms_pkg::IDX_W-1:0]       out_col;
	logic signed [31:0]              result_value;
	logic                            overflow;
	logic                            index_error;
	logic                            last;

	modport source(output valid, out_row, out_col, result_value, overflow, index_error, last,
		input ready);
	modport sink(input valid, out_row, out_col, result_value, overflow, index_error, last,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sms_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module sms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sms_cell.sv =====
// One multiply-accumulate cell of the chain: holds one column and one row of B,
// multiplies the passing A element and forwards it to the next cell. Uses sms_pkg.
`default_nettype none
module sms_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sms_pkg::idx_t      cell_idx,
	input  wire sms_pkg::mode_t     mode,
	input  wire sms_pkg::bload_t    bload,
	input  wire sms_pkg::feed_t     feed_in,
	output sms_pkg::feed_t          feed_out,
	output sms_pkg::cell_res_t      res
);
	import sms_pkg::*;

	data_t bcol_q [MAX_DIM];
	data_t brow_q [MAX_DIM];
	feed_t feed_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic vld_s1, first_s1, last_s1;
	acc_t acc_q;
	logic sat_q, done_q;
	data_t b_op;
	logic signed [ACC_W:0] base, sum;
	logic ovf;

	always_ff @(posedge clk) begin
		if (bload.we && bload.col == cell_idx) begin
			bcol_q[bload.row] <= bload.value;
		end
		if (bload.we && bload.row == cell_idx) begin
			brow_q[bload.col] <= bload.value;
		end
	end

	always_comb begin
		b_op = (mode == MODE_ABT) ? brow_q[feed_q.k] : bcol_q[feed_q.k];
		base = first_s1 ? '0 : {acc_q[ACC_W-1], acc_q};
		sum  = base + (ACC_W+1)'(prod_s1);
		ovf  = sum[ACC_W] != sum[ACC_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_q   <= '0;
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			feed_q   <= feed_in;
			vld_s1   <= feed_q.vld;
			first_s1 <= feed_q.first;
			last_s1  <= feed_q.last;
			done_q   <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(feed_q.a) * PROD_W'(b_op);
		if (vld_s1) begin
			if (ovf) begin
				acc_q <= sum[ACC_W] ? ACC_MIN : ACC_MAX;
			end else begin
				acc_q <= sum[ACC_W-1:0];
			end
			sat_q <= (first_s1 ? 1'b0 : sat_q) | ovf;
		end
	end

	assign feed_out = feed_q;
	assign res = '{done: done_q, sat: sat_q, acc: acc_q};
endmodule
`default_nettype wire

// ===== hw/rtl/sms_scale.sv =====
// Scaling pipeline: multiplies a finished sum by the scale factor in two
// partial products, shifts with floor rounding and saturates. Uses sms_pkg.
`default_nettype none
module sms_scale (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sms_pkg::scale_t    scale,
	input  wire sms_pkg::scale_in_t sc_in,
	output sms_pkg::scale_out_t     sc_out
);
	import sms_pkg::*;

	logic signed [HALF_W+SCALE_W-1:0] ph_s1;
	logic signed [HALF_W+SCALE_W:0]   pl_s1;
	logic signed [SUM_W-1:0]          sum_s2, q;
	logic [2:0]                       vld_s;
	logic                             sat_s1, sat_s2;
	idx_t                             col_s1, col_s2;
	logic                             ovf;
	scale_out_t                       out_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[1:0], sc_in.vld};
		end
	end

	always_comb begin
		q   = sum_s2 >>> SHIFT;
		ovf = (q > SUM_W'(DATA_MAX)) || (q < SUM_W'(DATA_MIN));
	end

	always_ff @(posedge clk) begin
		ph_s1  <= (HALF_W+SCALE_W)'($signed(sc_in.acc[ACC_W-1:HALF_W]))
			* (HALF_W+SCALE_W)'(scale);
		pl_s1  <= (HALF_W+SCALE_W+1)'($signed({1'b0, sc_in.acc[HALF_W-1:0]}))
			* (HALF_W+SCALE_W+1)'(scale);
		sat_s1 <= sc_in.sat;
		col_s1 <= sc_in.col;
		sum_s2 <= (SUM_W'(ph_s1) <<< HALF_W) + SUM_W'(pl_s1);
		sat_s2 <= sat_s1;
		col_s2 <= col_s1;
		out_s3.sat <= sat_s2 | ovf;
		out_s3.col <= col_s2;
		if (ovf) begin
			out_s3.value <= q[SUM_W-1] ? DATA_MIN : DATA_MAX;
		end else begin
			out_s3.value <= q[DATA_WIDTH-1:0];
		end
	end

	always_comb begin
		sc_out = '{vld: vld_s[2], sat: out_s3.sat, col: out_s3.col, value: out_s3.value};
	end
endmodule
`default_nettype wire

// ===== hw/rtl/scaled_matrix_product.sv =====
// Top level of the scaled matrix product block: APB registers, operand A store,
// the chain of MAC cells, the scaling pipeline, the result store and the sequencer.
// Depends on sms_pkg, sms_if, sms_ram, sms_cell and sms_scale.
//
//  channel   direction  handshake        content
//  in_ch     sink       valid/ready      func, row, col, value
//  out_ch    source     valid/ready      out_row, out_col, result_value, flags
//  apb       slave      psel/penable     five configuration registers
//
// A valid load is written into its store and leaves the block idle; an out-of-range load offers
// its answer in the next cycle. A compute transaction streams, for each row, n A elements from
// the A store port through the cell chain, then drains through the scaling pipeline, and each
// result is read from the result store through the states ST_RD, ST_LD and ST_RESP.
// Reset leaves the stores uninitialized and the registers at their defaults.
// A stalled output holds the sequencer; no input is taken until a run is delivered.
`default_nettype none
module scaled_matrix_product (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	sms_in_if.sink                          in_ch,
	sms_out_if.source                       out_ch,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sms_pkg::APB_AW-1:0] paddr,
	input  wire logic [sms_pkg::APB_DW-1:0] pwdata,
	output logic      [sms_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);
	import sms_pkg::*;

	typedef struct packed {
		idx_t  row;
		idx_t  col;
		data_t value;
		logic  sat;
		logic  err;
		logic  last;
	} out_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
		idx_t k;
	} iss_t;

	dim_t   rows_cfg_q, inner_cfg_q, cols_cfg_q;
	mode_t  mode_cfg_q;
	scale_t scale_q;

	state_t state_q, state_d;
	idx_t   i_q, i_d, j_q, j_d, k_q, k_d;
	dim_t   rows_q, rows_d, cols_q, cols_d, n_q, n_d;
	mode_t  mode_q, mode_d;
	out_t   out_q, out_d;
	iss_t   iss_q, iss_d;

	dim_t   rows_c, cols_c, n_c, dr, dc;
	logic   a_we;
	addr_t  a_raddr, r_raddr;
	logic [DATA_WIDTH-1:0] a_rdata;
	logic [DATA_WIDTH:0]   r_rdata;
	bload_t bload;
	feed_t  chain [MAX_DIM+1];
	cell_res_t cres [MAX_DIM];
	logic [MAX_DIM-1:0] done_vec;
	scale_in_t  sc_in;
	scale_out_t sc_out;
	logic   cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= dim_t'(8);
			inner_cfg_q <= dim_t'(8);
			cols_cfg_q  <= dim_t'(8);
			mode_cfg_q  <= MODE_AB;
			scale_q     <= scale_t'(65536);
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_ROWS:  rows_cfg_q  <= pwdata[DIM_W-1:0];
				REG_INNER: inner_cfg_q <= pwdata[DIM_W-1:0];
				REG_COLS:  cols_cfg_q  <= pwdata[DIM_W-1:0];
				REG_MODE:  mode_cfg_q  <= mode_t'(pwdata[1:0]);
				REG_SCALE: scale_q     <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ROWS:  prdata = APB_DW'(rows_cfg_q);
			REG_INNER: prdata = APB_DW'(inner_cfg_q);
			REG_COLS:  prdata = APB_DW'(cols_cfg_q);
			REG_MODE:  prdata = APB_DW'(mode_cfg_q);
			REG_SCALE: prdata = APB_DW'($unsigned(scale_q));
			default:   prdata = '0;
		endcase
	end

	sms_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (mk_addr(in_ch.row, in_ch.col)),
		.wdata (in_ch.value[DATA_WIDTH-1:0]),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	sms_ram #(.WIDTH(DATA_WIDTH+1), .DEPTH(DEPTH)) u_result_store (
		.clk   (clk),
		.we    (sc_out.vld),
		.waddr (mk_addr(i_q, sc_out.col)),
		.wdata ({sc_out.sat, sc_out.value}),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	assign chain[0] = '{vld: iss_q.vld, first: iss_q.first, last: iss_q.last, k: iss_q.k,
		a: a_rdata};

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		sms_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (idx_t'(g)),
			.mode     (mode_q),
			.bload    (bload),
			.feed_in  (chain[g]),
			.feed_out (chain[g+1]),
			.res      (cres[g])
		);
		assign done_vec[g] = cres[g].done;
	end

	always_comb begin
		sc_in = '0;
		for (int g = 0; g < MAX_DIM; g++) begin
			if (cres[g].done) begin
				sc_in.vld = 1'b1;
				sc_in.sat = cres[g].sat;
				sc_in.col = idx_t'(g);
				sc_in.acc = cres[g].acc;
			end
		end
	end

	sms_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.scale  (scale_q),
		.sc_in  (sc_in),
		.sc_out (sc_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			iss_q   <= iss_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		rows_q <= rows_d;
		cols_q <= cols_d;
		n_q    <= n_d;
		mode_q <= mode_d;
		out_q  <= out_d;
	end

	always_comb begin
		rows_c = dim_clamp(rows_cfg_q);
		cols_c = dim_clamp(cols_cfg_q);
		n_c    = dim_clamp(inner_cfg_q);
		if (func_t'(in_ch.func) == FUNC_LOAD_A) begin
			dr = (mode_cfg_q == MODE_ATB) ? n_c : rows_c;
			dc = (mode_cfg_q == MODE_ATB) ? rows_c : n_c;
		end else begin
			dr = (mode_cfg_q == MODE_ABT) ? cols_c : n_c;
			dc = (mode_cfg_q == MODE_ABT) ? n_c : cols_c;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		rows_d  = rows_q;
		cols_d  = cols_q;
		n_d     = n_q;
		mode_d  = mode_q;
		out_d   = out_q;
		iss_d   = '0;
		a_we    = 1'b0;
		bload   = '{we: 1'b0, row: in_ch.row, col: in_ch.col,
			value: in_ch.value[DATA_WIDTH-1:0]};
		in_ch.ready = 1'b0;
		a_raddr = (mode_q == MODE_ATB) ? mk_addr(k_q, i_q) : mk_addr(i_q, k_q);
		r_raddr = (mode_q == MODE_SYM && j_q < i_q) ? mk_addr(j_q, i_q) : mk_addr(i_q, j_q);
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					case (func_t'(in_ch.func))
						FUNC_LOAD_A, FUNC_LOAD_B: begin
							if (DIM_W'(in_ch.row) >= dr || DIM_W'(in_ch.col) >= dc) begin
								out_d = '{row: in_ch.row, col: in_ch.col, value: '0,
									sat: 1'b0, err: 1'b1, last: 1'b1};
								state_d = ST_RESP;
							end else if (func_t'(in_ch.func) == FUNC_LOAD_A) begin
								a_we = 1'b1;
							end else begin
								bload.we = 1'b1;
							end
						end
						FUNC_COMPUTE: begin
							rows_d  = rows_c;
							cols_d  = cols_c;
							n_d     = n_c;
							mode_d  = mode_cfg_q;
							i_d     = '0;
							j_d     = '0;
							k_d     = '0;
							state_d = ST_FEED;
						end
						default: ;
					endcase
				end
			end
			ST_FEED: begin
				iss_d = '{vld: 1'b1, first: k_q == '0, last: DIM_W'(k_q) == n_q - dim_t'(1),
					k: k_q};
				k_d = k_q + idx_t'(1);
				if (DIM_W'(k_q) == n_q - dim_t'(1)) begin
					state_d = ST_WAITROW;
				end
			end
			ST_WAITROW: begin
				if (sc_out.vld && sc_out.col == idx_t'(MAX_DIM-1)) begin
					j_d     = '0;
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_LD;
			end
			ST_LD: begin
				out_d = '{row: i_q, col: j_q, value: r_rdata[DATA_WIDTH-1:0],
					sat: r_rdata[DATA_WIDTH], err: 1'b0,
					last: DIM_W'(i_q) == rows_q - dim_t'(1) && DIM_W'(j_q) == cols_q - dim_t'(1)};
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_ch.ready) begin
					if (out_q.last) begin
						state_d = ST_IDLE;
					end else if (DIM_W'(j_q) == cols_q - dim_t'(1)) begin
						i_d     = i_q + idx_t'(1);
						j_d     = '0;
						k_d     = '0;
						state_d = ST_FEED;
					end else begin
						j_d     = j_q + idx_t'(1);
						state_d = ST_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_ch.valid        = state_q == ST_RESP;
	assign out_ch.out_row      = out_q.row;
	assign out_ch.out_col      = out_q.col;
	assign out_ch.result_value = 32'(out_q.value);
	assign out_ch.overflow     = out_q.sat;
	assign out_ch.index_error  = out_q.err;
	assign out_ch.last         = out_q.last;

`ifndef SYNTHESIS
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(done_vec))
		else $error("more than one cell finished in the same cycle");
	a_wr_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sc_out.vld |-> state_q == ST_WAITROW)
		else $error("scaled result written outside the row wait");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.index_error) |-> out_ch.last)
		else $error("index error result without last");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
		else $error("block not idle after the final transaction");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_scaled_matrix_product.sv =====
// Self-checking testbench for scaled_matrix_product: loads, out-of-range loads and
// computes in every product mode, checked against an in-bench predictor of the block.
// Depends on sms_pkg, sms_if and the RTL of the block.
`timescale 1ns / 100ps
module tb_scaled_matrix_product;
	import sms_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic [1:0] func;
		idx_t       row;
		idx_t       col;
		data_t      value;
	} element_op_t;

	typedef struct {
		idx_t  row;
		idx_t  col;
		data_t value;
		logic  ovf;
		logic  err;
		logic  last;
	} result_elem_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	sms_in_if in_ch();
	sms_out_if out_ch();

	scaled_matrix_product dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	element_op_t op_q[$];
	result_elem_t product_q[$];
	element_op_t cur_op;

	data_t a_mem[DEPTH];
	data_t b_mem[DEPTH];
	bit a_written[DEPTH];
	bit b_written[DEPTH];
	logic [3:0] cfg_rows, cfg_inner, cfg_cols;
	logic [1:0] cfg_mode;
	data_t cfg_scale;

	int mismatches = 0;
	int cycles = 0;
	int gap_left = 0;
	int burst_left = 4;
	int stall_sel = 0;
	int hold_left = 0;
	bit hold_armed = 0;
	bit rx_hold_req = 0;
	int total_items = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int clamp_dim(logic [3:0] r);
		if (r == 0) begin
			return 1;
		end else if (r > MAX_DIM) begin
			return MAX_DIM;
		end
		return r;
	endfunction

	function automatic void region_a(output int nr, output int nc);
		nr = (cfg_mode == MODE_ATB) ? clamp_dim(cfg_inner) : clamp_dim(cfg_rows);
		nc = (cfg_mode == MODE_ATB) ? clamp_dim(cfg_rows) : clamp_dim(cfg_inner);
	endfunction

	function automatic void region_b(output int nr, output int nc);
		nr = (cfg_mode == MODE_ABT) ? clamp_dim(cfg_cols) : clamp_dim(cfg_inner);
		nc = (cfg_mode == MODE_ABT) ? clamp_dim(cfg_inner) : clamp_dim(cfg_cols);
	endfunction

	function automatic void product_element(int i, int j, output data_t v, output logic ovf);
		logic signed [63:0] acc;
		logic signed [63:0] p;
		logic signed [64:0] t;
		logic signed [127:0] w;
		data_t a, b;
		int n;
		n = clamp_dim(cfg_inner);
		acc = 0;
		ovf = 0;
		for (int k = 0; k < n; k++) begin
			a = (cfg_mode == MODE_ATB) ? a_mem[k*MAX_DIM+i] : a_mem[i*MAX_DIM+k];
			b = (cfg_mode == MODE_ABT) ? b_mem[j*MAX_DIM+k] : b_mem[k*MAX_DIM+j];
			p = 64'(a) * 64'(b);
			t = acc + p;
			if (t[64] != t[63]) begin
				acc = t[64] ? ACC_MIN : ACC_MAX;
				ovf = 1;
			end else begin
				acc = t[63:0];
			end
		end
		w = acc * cfg_scale;
		w = w >>> SHIFT;
		if (w[127:31] != {97{w[127]}}) begin
			v = w[127] ? DATA_MIN : DATA_MAX;
			ovf = 1;
		end else begin
			v = w[31:0];
		end
	endfunction

	function automatic void predict_transaction(element_op_t op);
		result_elem_t r;
		int nr, nc, rows, cols;
		if (op.func == FUNC_LOAD_A || op.func == FUNC_LOAD_B) begin
			if (op.func == FUNC_LOAD_A) region_a(nr, nc);
			else region_b(nr, nc);
			if (op.row >= nr || op.col >= nc) begin
				r.row = op.row;
				r.col = op.col;
				r.value = 0;
				r.ovf = 0;
				r.err = 1;
				r.last = 1;
				product_q.push_back(r);
			end else if (op.func == FUNC_LOAD_A) begin
				a_mem[op.row*MAX_DIM+op.col] = op.value;
			end else begin
				b_mem[op.row*MAX_DIM+op.col] = op.value;
			end
		end else if (op.func == FUNC_COMPUTE) begin
			rows = clamp_dim(cfg_rows);
			cols = clamp_dim(cfg_cols);
			for (int i = 0; i < rows; i++) begin
				for (int j = 0; j < cols; j++) begin
					if (cfg_mode == MODE_SYM && j < i) product_element(j, i, r.value, r.ovf);
					else product_element(i, j, r.value, r.ovf);
					r.row = i;
					r.col = j;
					r.err = 0;
					r.last = (i == rows - 1 && j == cols - 1);
					product_q.push_back(r);
				end
			end
		end
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		element_op_t nxt;
		logic nv;
		if (!arst_n) begin
			in_ch.valid <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) predict_transaction(cur_op);
			nv = 0;
			nxt = cur_op;
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
			end else if (op_q.size() > 0) begin
				nxt = op_q.pop_front();
				nv = 1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			cur_op = nxt;
			in_ch.valid <= nv;
			in_ch.func <= nxt.func;
			in_ch.row <= nxt.row;
			in_ch.col <= nxt.col;
			in_ch.value <= nxt.value;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic rdy;
		if (!arst_n) begin
			out_ch.ready <= 0;
		end else begin
			if (rx_hold_req && !hold_armed) begin
				hold_armed = 1;
				hold_left = 1500;
			end
			if (cycles % 64 == 0) stall_sel = $urandom_range(0, 2);
			case (stall_sel)
			0: rdy = 1;
			1: rdy = ($urandom_range(0, 9) < 7);
			default: rdy = ($urandom_range(0, 9) < 3);
			endcase
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				rdy = 0;
			end
			out_ch.ready <= rdy;
		end
	end

	always @(posedge clk) begin
		result_elem_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (product_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transaction: row %0d col %0d value %h",
						out_ch.out_row, out_ch.out_col, out_ch.result_value);
			end else begin
				e = product_q.pop_front();
				if (out_ch.out_row !== e.row || out_ch.out_col !== e.col ||
					out_ch.result_value !== e.value || out_ch.overflow !== e.ovf ||
					out_ch.index_error !== e.err || out_ch.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected r%0d c%0d %h ovf%b err%b last%b, got r%0d c%0d %h ovf%b err%b last%b",
							e.row, e.col, e.value, e.ovf, e.err, e.last,
							out_ch.out_row, out_ch.out_col, out_ch.result_value,
							out_ch.overflow, out_ch.index_error, out_ch.last);
				end
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= APB_AW'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
		REG_ROWS: cfg_rows = v[3:0];
		REG_INNER: cfg_inner = v[3:0];
		REG_COLS: cfg_cols = v[3:0];
		REG_MODE: cfg_mode = v[1:0];
		default: cfg_scale = v;
		endcase
	endtask

	task automatic configure(logic [3:0] r, logic [3:0] n, logic [3:0] c, logic [1:0] m,
		logic [31:0] k);
		reg_write(REG_ROWS, r);
		reg_write(REG_INNER, n);
		reg_write(REG_COLS, c);
		reg_write(REG_MODE, m);
		reg_write(REG_SCALE, k);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (op_q.size() != 0 || in_ch.valid || product_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_op(logic [1:0] f, idx_t r, idx_t c, data_t v);
		element_op_t op;
		int nr, nc;
		op.func = f;
		op.row = r;
		op.col = c;
		op.value = v;
		op_q.push_back(op);
		if (f != FUNC_UNUSED) total_items++;
		if (f == FUNC_LOAD_A || f == FUNC_LOAD_B) begin
			if (f == FUNC_LOAD_A) region_a(nr, nc);
			else region_b(nr, nc);
			if (r < nr && c < nc) begin
				if (f == FUNC_LOAD_A) a_written[r*MAX_DIM+c] = 1;
				else b_written[r*MAX_DIM+c] = 1;
			end
		end
	endtask

	function automatic data_t rand_value();
		case ($urandom_range(0, 7))
		0: return DATA_MAX;
		1: return DATA_MIN;
		2: return $urandom();
		default: return $urandom_range(0, 32'h80000) - 32'h40000;
		endcase
	endfunction

	task automatic push_compute();
		int nr, nc;
		region_a(nr, nc);
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (!a_written[r*MAX_DIM+c]) push_op(FUNC_LOAD_A, r, c, rand_value());
		region_b(nr, nc);
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (!b_written[r*MAX_DIM+c]) push_op(FUNC_LOAD_B, r, c, rand_value());
		push_op(FUNC_COMPUTE, $urandom(), $urandom(), $urandom());
	endtask

	task automatic random_phase(int count);
		int sel, nr, nc, f;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			f = $urandom_range(0, 1);
			if (f == 0) region_a(nr, nc);
			else region_b(nr, nc);
			if (sel < 8) begin
				push_op(f, $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
			end else if (sel < 11) begin
				push_op(FUNC_UNUSED, $urandom(), $urandom(), $urandom());
			end else if (sel < 18) begin
				push_compute();
			end else begin
				push_op(f, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), rand_value());
			end
		end
		push_compute();
	endtask

	function automatic logic [3:0] rand_dim();
		case ($urandom_range(0, 11))
		0: return 0;
		1: return 15;
		2: return 9;
		default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic logic [31:0] rand_scale();
		case ($urandom_range(0, 7))
		0: return 32'h00010000;
		1: return 32'h7FFFFFFF;
		2: return 32'h80000000;
		3: return 0;
		4: return $urandom();
		default: return $urandom_range(0, 32'h40000) - 32'h20000;
		endcase
	endfunction

	initial begin
		int ph;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_ch.valid = 0;
		in_ch.func = FUNC_LOAD_A;
		in_ch.row = 0;
		in_ch.col = 0;
		in_ch.value = 0;
		out_ch.ready = 0;
		cur_op.func = FUNC_LOAD_A;
		cur_op.row = 0;
		cur_op.col = 0;
		cur_op.value = 0;
		cfg_rows = 8;
		cfg_inner = 8;
		cfg_cols = 8;
		cfg_mode = MODE_AB;
		cfg_scale = 32'h00010000;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		configure(2, 2, 2, MODE_AB, 32'h00010000);
		push_op(FUNC_LOAD_A, 0, 0, DATA_MAX);
		push_op(FUNC_LOAD_A, 0, 1, DATA_MAX);
		push_op(FUNC_LOAD_A, 1, 0, DATA_MIN);
		push_op(FUNC_LOAD_A, 1, 1, -1);
		push_op(FUNC_LOAD_B, 0, 0, DATA_MAX);
		push_op(FUNC_LOAD_B, 0, 1, DATA_MIN);
		push_op(FUNC_LOAD_B, 1, 0, DATA_MAX);
		push_op(FUNC_LOAD_B, 1, 1, 0);
		push_op(FUNC_COMPUTE, 0, 0, 0);
		push_op(FUNC_LOAD_A, 7, 7, 5);
		push_op(FUNC_LOAD_B, 2, 0, 5);
		push_op(FUNC_LOAD_A, 0, 2, DATA_MIN);
		push_op(FUNC_UNUSED, 7, 7, DATA_MIN);
		push_op(FUNC_LOAD_A, 1, 1, 32'h00020000);
		push_op(FUNC_LOAD_A, 0, 0, 32'h00010000);
		push_op(FUNC_LOAD_B, 1, 1, 32'hFFFF8000);
		push_op(FUNC_COMPUTE, 7, 7, -1);
		wait_drained();
		configure(2, 2, 2, MODE_SYM, 32'h80000000);
		push_compute();
		wait_drained();
		configure(2, 2, 2, MODE_ATB, 32'h7FFFFFFF);
		push_compute();
		wait_drained();
		configure(2, 2, 2, MODE_ABT, 0);
		push_compute();
		wait_drained();

		ph = 0;
		while (total_items < 380) begin
			if (ph == 0) configure(8, 8, 8, MODE_AB, 32'h00010000);
			else if (ph == 1) configure(0, 15, 0, MODE_SYM, 32'hFFFF0000);
			else configure(rand_dim(), rand_dim(), rand_dim(), $urandom_range(0, 3),
				rand_scale());
			if (ph == 2) rx_hold_req = 1;
			random_phase(24);
			wait_drained();
			ph++;
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && product_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
